/* hw/rtl/bal_pkg.sv */
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types, widths and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int CMD_W  = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int IDXO_W = 5;
  localparam int CNTO_W = 5;
  localparam int CAP_W  = 5;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ST_W + IDXO_W + VAL_W + CNTO_W + 7) / 8) * 8;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_ERASE      = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_VISIT      = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  function automatic entry_t to_entry(input logic [VAL_W-1:0] v);
    return ENTRY_WIDTH'(v);
  endfunction

  function automatic logic [VAL_W-1:0] to_word(input entry_t e);
    return VAL_W'(e);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bal_store.sv */
// ----------------------------------------------------------------------------
// bal_store
// Entry register file: parallel shift up on insert, shift down on remove,
// one indexed read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_store (
  input  wire logic                      clk,
  input  wire bal_pkg::wr_t              wr,
  input  wire logic [bal_pkg::IDX_W-1:0] rd_addr,
  output bal_pkg::entry_t                rd_data
);

  bal_pkg::entry_t entries [bal_pkg::DEPTH];

  for (genvar i = 0; i < bal_pkg::DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      case (wr.op)
        bal_pkg::OP_INSERT: begin
          if (bal_pkg::IDX_W'(i) == wr.addr) begin
            entries[i] <= wr.data;
          end else if (bal_pkg::IDX_W'(i) > wr.addr) begin
            if (i > 0) begin
              entries[i] <= entries[(i > 0) ? i - 1 : 0];
            end
          end
        end
        bal_pkg::OP_REMOVE: begin
          if (bal_pkg::IDX_W'(i) >= wr.addr) begin
            if (i < bal_pkg::DEPTH - 1) begin
              entries[i] <= entries[(i < bal_pkg::DEPTH - 1) ? i + 1 : i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_data = entries[rd_addr];

endmodule

`default_nettype wire

/* hw/rtl/bal_seq.sv */
// ----------------------------------------------------------------------------
// bal_seq
// Command sequencer: decodes a request, drives the entry store, walks the
// list through one shared comparator and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [bal_pkg::CAP_W-1:0]  capacity,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bal_pkg::CMD_W-1:0]  command,
  input  wire logic [bal_pkg::POS_W-1:0]  position,
  input  wire logic [bal_pkg::VAL_W-1:0]  value_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [bal_pkg::ST_W-1:0]        status,
  output logic [bal_pkg::IDXO_W-1:0]      index_out,
  output logic [bal_pkg::VAL_W-1:0]       value_out,
  output logic [bal_pkg::CNTO_W-1:0]      count_out,
  output logic                            last,
  output bal_pkg::wr_t                    wr,
  output logic [bal_pkg::IDX_W-1:0]       rd_addr,
  input  wire bal_pkg::entry_t            rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_OUT
  } state_t;

  localparam int CW = bal_pkg::CMP_W;

  state_t                        state;
  bal_pkg::cmd_t                 cmd_r;
  logic [bal_pkg::POS_W-1:0]     pos_r;
  logic [bal_pkg::VAL_W-1:0]     key_r;
  logic [bal_pkg::CNT_W-1:0]     cnt;
  logic [bal_pkg::CNT_W-1:0]     idx;

  logic                          in_acc;
  logic [CW-1:0]                 cnt_x;
  logic [CW-1:0]                 pos_x;
  logic [CW-1:0]                 cap_x;
  logic [CW-1:0]                 lim_x;
  logic [CW-1:0]                 addr_x;
  bal_pkg::status_t              exec_st;
  bal_pkg::op_t                  exec_op;
  logic [bal_pkg::CNT_W-1:0]     cnt_next;
  logic                          match;
  logic                          walk_last;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready && last);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  assign cnt_x = CW'(cnt);
  assign pos_x = CW'(pos_r);
  assign cap_x = CW'(capacity);
  assign lim_x = (cap_x < CW'(bal_pkg::DEPTH)) ? cap_x : CW'(bal_pkg::DEPTH);

  always_comb begin
    exec_st = bal_pkg::ST_OK;
    exec_op = bal_pkg::OP_NONE;
    addr_x  = '0;
    case (cmd_r)
      bal_pkg::CMD_INSERT, bal_pkg::CMD_PUSH_FRONT, bal_pkg::CMD_PUSH_BACK: begin
        addr_x = (cmd_r == bal_pkg::CMD_INSERT)     ? pos_x :
                 (cmd_r == bal_pkg::CMD_PUSH_FRONT) ? '0    : cnt_x;
        if (addr_x > cnt_x) begin
          exec_st = bal_pkg::ST_BADPOS;
        end else if (cnt_x >= lim_x) begin
          exec_st = bal_pkg::ST_FULL;
        end else begin
          exec_op = bal_pkg::OP_INSERT;
        end
      end
      bal_pkg::CMD_ERASE, bal_pkg::CMD_POP_FRONT, bal_pkg::CMD_POP_BACK: begin
        addr_x = (cmd_r == bal_pkg::CMD_ERASE)     ? pos_x :
                 (cmd_r == bal_pkg::CMD_POP_FRONT) ? '0    : cnt_x - CW'(1);
        if (cnt == '0) begin
          exec_st = bal_pkg::ST_EMPTY;
        end else if (addr_x >= cnt_x) begin
          exec_st = bal_pkg::ST_BADPOS;
        end else begin
          exec_op = bal_pkg::OP_REMOVE;
        end
      end
      bal_pkg::CMD_FIND: begin
        exec_st = bal_pkg::ST_NOTFOUND;
      end
      default: begin
        exec_st = bal_pkg::ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    case (exec_op)
      bal_pkg::OP_INSERT: cnt_next = cnt + bal_pkg::CNT_W'(1);
      bal_pkg::OP_REMOVE: cnt_next = cnt - bal_pkg::CNT_W'(1);
      default:            cnt_next = cnt;
    endcase
  end

  assign wr.op   = (state == S_EXEC) ? exec_op : bal_pkg::OP_NONE;
  assign wr.addr = bal_pkg::IDX_W'(addr_x);
  assign wr.data = bal_pkg::to_entry(key_r);

  assign rd_addr   = idx[bal_pkg::IDX_W-1:0];
  assign match     = (rd_data == bal_pkg::to_entry(key_r));
  assign walk_last = ((idx + bal_pkg::CNT_W'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      if (in_acc) begin
        cmd_r <= bal_pkg::cmd_t'(command);
        pos_r <= position;
        key_r <= value_in;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx <= '0;
          if ((cmd_r == bal_pkg::CMD_FIND || cmd_r == bal_pkg::CMD_VISIT) && cnt != '0) begin
            state <= S_WALK;
          end else begin
            cnt       <= cnt_next;
            status    <= exec_st;
            index_out <= '0;
            value_out <= '0;
            count_out <= bal_pkg::CNTO_W'(cnt_next);
            last      <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_WALK: begin
          count_out <= bal_pkg::CNTO_W'(cnt);
          if (cmd_r == bal_pkg::CMD_VISIT) begin
            status    <= bal_pkg::ST_OK;
            index_out <= bal_pkg::IDXO_W'(idx);
            value_out <= bal_pkg::to_word(rd_data);
            last      <= walk_last;
            state     <= S_OUT;
          end else if (match) begin
            status    <= bal_pkg::ST_OK;
            index_out <= bal_pkg::IDXO_W'(idx);
            value_out <= '0;
            last      <= 1'b1;
            state     <= S_OUT;
          end else if (walk_last) begin
            status    <= bal_pkg::ST_NOTFOUND;
            index_out <= '0;
            value_out <= '0;
            last      <= 1'b1;
            state     <= S_OUT;
          end else begin
            idx <= idx + bal_pkg::CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (!last) begin
              idx   <= idx + bal_pkg::CNT_W'(1);
              state <= S_WALK;
            end else if (in_acc) begin
              state <= S_EXEC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bounded_array_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of up to DEPTH entries with insert, push, erase, pop, find
// and visit requests on stream ports and a capacity register.
// ----------------------------------------------------------------------------
// Insert, push, erase and pop: the request passes through EXEC and its result is held in OUT.
// Find: entries are compared one per cycle in the shared comparator.
// Visit: one result per entry; the walk waits in OUT until each result is taken.
// A new request can be taken in the same cycle as the last result of the previous one.
// Reset: fill count cleared, capacity set to 16; entry storage is not cleared.
`default_nettype none

module bounded_array_list_engine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bal_pkg::CAP_W-1:0]       cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [bal_pkg::S_TDATA_W-1:0]   s_tdata,  // position, value_in
  input  wire logic [bal_pkg::CMD_W-1:0]       s_tuser,  // command
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // status, index_out, value_out, count_out
  output logic [bal_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                 m_tlast
);

  localparam int VL = bal_pkg::POS_W;

  logic [bal_pkg::CAP_W-1:0]  capacity;
  logic [bal_pkg::ST_W-1:0]   status;
  logic [bal_pkg::IDXO_W-1:0] index_out;
  logic [bal_pkg::VAL_W-1:0]  value_out;
  logic [bal_pkg::CNTO_W-1:0] count_out;
  bal_pkg::wr_t               wr;
  logic [bal_pkg::IDX_W-1:0]  rd_addr;
  bal_pkg::entry_t            rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bal_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  bal_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .command   (s_tuser),
    .position  (s_tdata[VL-1:0]),
    .value_in  (s_tdata[VL+bal_pkg::VAL_W-1:VL]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .index_out (index_out),
    .value_out (value_out),
    .count_out (count_out),
    .last      (m_tlast),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bal_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_tdata = bal_pkg::M_TDATA_W'({count_out, value_out, index_out, status});

endmodule

`default_nettype wire

/* hw/rtl/bal_checker.sv */
// ----------------------------------------------------------------------------
// bal_checker
// Port-level checks for the bounded array list engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [bal_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                          m_tlast
);

  logic [bal_pkg::ST_W-1:0]   st;
  logic [bal_pkg::CNTO_W-1:0] cnt;

  assign st  = m_tdata[bal_pkg::ST_W-1:0];
  assign cnt = m_tdata[bal_pkg::ST_W+bal_pkg::IDXO_W+bal_pkg::VAL_W +: bal_pkg::CNTO_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != bal_pkg::ST_OK |-> m_tlast)
    else $error("failure result not marked last");

  a_no_req_mid_visit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken while a visit is still streaming");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= bal_pkg::CNTO_W'(bal_pkg::DEPTH))
    else $error("fill count beyond depth");

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
